/* design/imgrot_pkg.sv */
// Shared types, constants and helpers for the image region rotator.
package imgrot_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int SIDE       = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int POS_W      = $clog2(SIDE);
    localparam int DIM_W      = 7;
    localparam int CNT_W      = POS_W + 1;
    localparam int ADDR_W     = 2 * POS_W;
    localparam int DEPTH      = SIDE * SIDE;
    localparam int COORD_W    = 10;
    localparam int PIX_W      = 24;
    localparam int ANG_W      = 9;

    localparam logic [PIX_W-1:0] WHITE = 24'hFF_FFFF;

    localparam logic [ANG_W-1:0] ANGLE_90  = 9'd90;
    localparam logic [ANG_W-1:0] ANGLE_180 = 9'd180;
    localparam logic [ANG_W-1:0] ANGLE_270 = 9'd270;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_ROTATE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_RECT  = 2'd1;
    localparam logic [1:0] STAT_BAD_ANGLE = 2'd2;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_LEFT   = 3'd2;
    localparam logic [2:0] REG_TOP    = 3'd3;
    localparam logic [2:0] REG_RIGHT  = 3'd4;
    localparam logic [2:0] REG_BOTTOM = 3'd5;
    localparam logic [2:0] REG_ANGLE  = 3'd6;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PIX,
        OP_W2S,
        OP_S2W,
        OP_P2S,
        OP_PAINT_X,
        OP_PAINT_Y,
        OP_S2P,
        OP_SWAP,
        OP_SWAP_MID
    } op_t;

    typedef enum logic [2:0] {
        SUB_NONE,
        SUB_RA,
        SUB_RB,
        SUB_WA,
        SUB_WB
    } sub_t;

    typedef struct packed {
        op_t        op;
        sub_t       sub;
        logic       load;
        logic       derive;
        logic       clr_cnt;
        logic       step;
        logic       swap_dims;
        logic       finish;
        logic       take_pix;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       rect_bad;
        logic       angle_bad;
        logic       angle_180;
        logic       whole;
        logic       dx_gt_dy;
        logic       dx_lt_dy;
        logic       dy_even;
        logic       empty;
        logic       last;
    } stat_t;

    function automatic coord_t to_c(input logic [DIM_W-1:0] v);
        to_c = coord_t'({{(COORD_W-DIM_W){1'b0}}, v});
    endfunction

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
        if (v == '0)
            sat_dim = DIM_W'(1);
        else if (v > lim)
            sat_dim = lim;
        else
            sat_dim = v;
    endfunction

endpackage

/* design/imgrot_regs.sv */
// Configuration registers and current picture dimensions behind the APB port.
module imgrot_regs
    import imgrot_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 swap_dims,
    output logic [DIM_W-1:0]     cur_w,
    output logic [DIM_W-1:0]     cur_h,
    output logic [POS_W-1:0]     x1,
    output logic [POS_W-1:0]     ty,
    output logic [POS_W-1:0]     x2,
    output logic [POS_W-1:0]     by,
    output logic [ANG_W-1:0]     ang
);

    logic [DIM_W-1:0] cur_w_reg, cur_h_reg;
    logic [POS_W-1:0] x1_reg, ty_reg, x2_reg, by_reg;
    logic [ANG_W-1:0] ang_reg;
    logic             wr;
    logic [2:0]       idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_w_reg <= DIM_W'(MAX_WIDTH);
            cur_h_reg <= DIM_W'(MAX_HEIGHT);
            x1_reg    <= '0;
            ty_reg    <= '0;
            x2_reg    <= POS_W'(SIDE - 1);
            by_reg    <= POS_W'(SIDE - 1);
            ang_reg   <= ANGLE_90;
        end
        else if (swap_dims)
        begin
            cur_w_reg <= cur_h_reg;
            cur_h_reg <= cur_w_reg;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_WIDTH:  cur_w_reg <= sat_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_WIDTH));
                REG_HEIGHT: cur_h_reg <= sat_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
                REG_LEFT:   x1_reg    <= pwdata[POS_W-1:0];
                REG_TOP:    ty_reg    <= pwdata[POS_W-1:0];
                REG_RIGHT:  x2_reg    <= pwdata[POS_W-1:0];
                REG_BOTTOM: by_reg    <= pwdata[POS_W-1:0];
                REG_ANGLE:  ang_reg   <= pwdata[ANG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WIDTH:  prdata = 32'(cur_w_reg);
            REG_HEIGHT: prdata = 32'(cur_h_reg);
            REG_LEFT:   prdata = 32'(x1_reg);
            REG_TOP:    prdata = 32'(ty_reg);
            REG_RIGHT:  prdata = 32'(x2_reg);
            REG_BOTTOM: prdata = 32'(by_reg);
            REG_ANGLE:  prdata = 32'(ang_reg);
            default:    prdata = '0;
        endcase
    end

    assign cur_w = cur_w_reg;
    assign cur_h = cur_h_reg;
    assign x1    = x1_reg;
    assign ty    = ty_reg;
    assign x2    = x2_reg;
    assign by    = by_reg;
    assign ang   = ang_reg;

endmodule

/* design/imgrot_dp.sv */
// Datapath: frame and scratch memories, loop counters, address generation, result registers.
module imgrot_dp
    import imgrot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [1:0]         kind,
    input  logic [POS_W-1:0]   row,
    input  logic [POS_W-1:0]   column,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    input  logic [DIM_W-1:0]   cur_w,
    input  logic [DIM_W-1:0]   cur_h,
    input  logic [POS_W-1:0]   x1,
    input  logic [POS_W-1:0]   ty,
    input  logic [POS_W-1:0]   x2,
    input  logic [POS_W-1:0]   by,
    input  logic [ANG_W-1:0]   ang,
    output logic               done,
    output logic [1:0]         status,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic [DIM_W-1:0]   result_width,
    output logic [DIM_W-1:0]   result_height
);

    logic [PIX_W-1:0] frame_mem [0:DEPTH-1];
    logic [PIX_W-1:0] scratch_mem [0:DEPTH-1];

    // transaction snapshot
    logic [1:0]       kind_reg;
    logic [POS_W-1:0] row_reg, col_reg;
    logic [PIX_W-1:0] pin_reg;
    logic [DIM_W-1:0] w_reg, h_reg;
    logic [POS_W-1:0] x1_reg, ty_reg, x2_reg, by_reg;
    logic [ANG_W-1:0] ang_reg;

    // rectangle geometry
    logic [POS_W-1:0] dx_reg, dy_reg;
    coord_t           xc_reg, mtop_reg, mbot_reg, mid_reg, cur_reg, sx_reg, py0_reg;
    coord_t           hdx_reg, hdy_reg;

    logic [CNT_W-1:0] i_reg, j_reg;
    logic [CNT_W-1:0] n_i, n_j;

    logic [PIX_W-1:0] frame_q_reg, scratch_q_reg, ta_reg;
    logic             fq_ok_reg;
    logic [PIX_W-1:0] frame_rd;

    coord_t           fr, fc, ci, cj;
    logic             f_ok, side_b;
    logic [ADDR_W-1:0] f_addr, s_addr;
    logic             f_we, s_we;
    logic [PIX_W-1:0] f_wdata;

    logic             done_reg;
    logic [1:0]       status_reg;
    logic [PIX_W-1:0] pout_reg;
    logic [DIM_W-1:0] rw_reg, rh_reg;

    logic [DIM_W-1:0] sum_x, sum_y;
    coord_t           yc, ceil_dx, ceil_dy;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            row_reg  <= row;
            col_reg  <= column;
            pin_reg  <= {red_in, green_in, blue_in};
            w_reg    <= cur_w;
            h_reg    <= cur_h;
            x1_reg   <= x1;
            ty_reg   <= ty;
            x2_reg   <= x2;
            by_reg   <= by;
            ang_reg  <= ang;
        end
    end

    assign sum_x   = DIM_W'(x1_reg) + DIM_W'(x2_reg);
    assign sum_y   = DIM_W'(ty_reg) + DIM_W'(by_reg);
    assign yc      = to_c(sum_y >> 1);
    assign ceil_dx = to_c((DIM_W'(x2_reg - x1_reg) + DIM_W'(1)) >> 1);
    assign ceil_dy = to_c((DIM_W'(by_reg - ty_reg) + DIM_W'(1)) >> 1);

    always_ff @(posedge clk)
    begin
        if (cmd.derive)
        begin
            dx_reg   <= x2_reg - x1_reg;
            dy_reg   <= by_reg - ty_reg;
            xc_reg   <= to_c(sum_x >> 1);
            mtop_reg <= to_c(h_reg) - coord_t'(1) - to_c(DIM_W'(ty_reg));
            mbot_reg <= to_c(h_reg) - coord_t'(1) - to_c(DIM_W'(by_reg));
            mid_reg  <= to_c(h_reg) - coord_t'(1) - to_c(DIM_W'(ty_reg))
                        - to_c(DIM_W'(by_reg - ty_reg) >> 1);
            cur_reg  <= to_c(h_reg) - coord_t'(1) - yc + ceil_dx;
            sx_reg   <= to_c(sum_x >> 1) - ceil_dy;
            py0_reg  <= to_c(h_reg) - yc - coord_t'(1);
            hdx_reg  <= to_c(DIM_W'(x2_reg - x1_reg) >> 1);
            hdy_reg  <= to_c(DIM_W'(by_reg - ty_reg) >> 1);
        end
    end

    // loop bounds per phase
    always_comb
    begin
        unique case (cmd.op)
            OP_W2S, OP_S2W:
            begin
                n_i = w_reg;
                n_j = h_reg;
            end
            OP_P2S, OP_S2P:
            begin
                n_i = CNT_W'(dx_reg) + CNT_W'(1);
                n_j = CNT_W'(dy_reg) + CNT_W'(1);
            end
            OP_PAINT_X:
            begin
                n_i = CNT_W'(dx_reg - dy_reg) >> 1;
                n_j = CNT_W'(dy_reg) + CNT_W'(1);
            end
            OP_PAINT_Y:
            begin
                n_i = (CNT_W'(dy_reg - dx_reg) >> 1) + CNT_W'(1);
                n_j = CNT_W'(dx_reg) + CNT_W'(1);
            end
            OP_SWAP:
            begin
                n_i = (CNT_W'(dy_reg) + CNT_W'(1)) >> 1;
                n_j = CNT_W'(dx_reg) + CNT_W'(1);
            end
            OP_SWAP_MID:
            begin
                n_i = CNT_W'(1);
                n_j = (CNT_W'(dx_reg) + CNT_W'(1)) >> 1;
            end
            default:
            begin
                n_i = CNT_W'(1);
                n_j = CNT_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_cnt)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (j_reg == n_j - CNT_W'(1))
            begin
                j_reg <= '0;
                i_reg <= i_reg + CNT_W'(1);
            end
            else
                j_reg <= j_reg + CNT_W'(1);
        end
    end

    assign ci     = to_c(DIM_W'(i_reg));
    assign cj     = to_c(DIM_W'(j_reg));
    assign side_b = (cmd.sub == SUB_RB) || (cmd.sub == SUB_WB);

    // frame coordinate of the current step
    always_comb
    begin
        unique case (cmd.op)
            OP_W2S:
            begin
                if (ang_reg == ANGLE_90)
                begin
                    fr = cj;
                    fc = to_c(w_reg) - coord_t'(1) - ci;
                end
                else
                begin
                    fr = to_c(h_reg) - coord_t'(1) - cj;
                    fc = ci;
                end
            end
            OP_S2W:
            begin
                fr = ci;
                fc = cj;
            end
            OP_P2S:
            begin
                if (ang_reg == ANGLE_90)
                begin
                    fr = mbot_reg + cj;
                    fc = to_c(DIM_W'(x1_reg)) + ci;
                end
                else
                begin
                    fr = mtop_reg - cj;
                    fc = to_c(DIM_W'(x2_reg)) - ci;
                end
            end
            OP_S2P:
            begin
                fr = cur_reg - ci;
                fc = sx_reg + cj;
            end
            OP_PAINT_X:
            begin
                fr = mtop_reg - cj;
                fc = side_b ? xc_reg - (hdy_reg + ci) : xc_reg + (hdy_reg + ci);
            end
            OP_PAINT_Y:
            begin
                fr = side_b ? py0_reg - (hdx_reg + ci) : py0_reg + (hdx_reg + ci);
                fc = to_c(DIM_W'(x1_reg)) + cj;
            end
            OP_SWAP:
            begin
                fr = side_b ? mbot_reg + ci : mtop_reg - ci;
                fc = side_b ? to_c(DIM_W'(x2_reg)) - cj : to_c(DIM_W'(x1_reg)) + cj;
            end
            OP_SWAP_MID:
            begin
                fr = mid_reg;
                fc = side_b ? to_c(DIM_W'(x2_reg)) - cj : to_c(DIM_W'(x1_reg)) + cj;
            end
            default:
            begin
                fr = to_c(DIM_W'(row_reg));
                fc = to_c(DIM_W'(col_reg));
            end
        endcase
    end

    assign f_ok   = (fr >= 0) && (fr < to_c(cur_h)) && (fc >= 0) && (fc < to_c(cur_w));
    assign f_addr = {fr[POS_W-1:0], fc[POS_W-1:0]};
    assign s_addr = {i_reg[POS_W-1:0], j_reg[POS_W-1:0]};

    assign frame_rd = fq_ok_reg ? frame_q_reg : '0;

    always_comb
    begin
        f_we    = 1'b0;
        s_we    = 1'b0;
        f_wdata = frame_rd;
        unique case (cmd.op)
            OP_PIX:
            begin
                f_we    = (cmd.sub == SUB_WA);
                f_wdata = pin_reg;
            end
            OP_W2S, OP_P2S:
                s_we = (cmd.sub == SUB_WA);
            OP_S2W, OP_S2P:
            begin
                f_we    = (cmd.sub == SUB_WA);
                f_wdata = scratch_q_reg;
            end
            OP_PAINT_X, OP_PAINT_Y:
            begin
                f_we    = (cmd.sub == SUB_WA) || (cmd.sub == SUB_WB);
                f_wdata = WHITE;
            end
            OP_SWAP, OP_SWAP_MID:
            begin
                f_we    = (cmd.sub == SUB_WA) || (cmd.sub == SUB_WB);
                f_wdata = (cmd.sub == SUB_WB) ? ta_reg : frame_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (f_we && f_ok)
            frame_mem[f_addr] <= f_wdata;
        frame_q_reg <= frame_mem[f_addr];
        fq_ok_reg   <= f_ok;
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            scratch_mem[s_addr] <= frame_rd;
        scratch_q_reg <= scratch_mem[s_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sub == SUB_RB)
            ta_reg <= frame_rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= cmd.status;
            pout_reg   <= cmd.take_pix ? frame_rd : '0;
            rw_reg     <= cur_w;
            rh_reg     <= cur_h;
        end
    end

    assign stat.kind      = kind_reg;
    assign stat.rect_bad  = (DIM_W'(x1_reg) >= w_reg) || (DIM_W'(x2_reg) >= w_reg)
                         || (DIM_W'(ty_reg) >= h_reg) || (DIM_W'(by_reg) >= h_reg)
                         || (x2_reg < x1_reg) || (by_reg < ty_reg);
    assign stat.angle_bad = (ang_reg != ANGLE_90) && (ang_reg != ANGLE_180)
                         && (ang_reg != ANGLE_270);
    assign stat.angle_180 = (ang_reg == ANGLE_180);
    assign stat.whole     = (x1_reg == '0) && (DIM_W'(x2_reg) == w_reg - DIM_W'(1))
                         && (ty_reg == '0) && (DIM_W'(by_reg) == h_reg - DIM_W'(1));
    assign stat.dx_gt_dy  = dx_reg > dy_reg;
    assign stat.dx_lt_dy  = dx_reg < dy_reg;
    assign stat.dy_even   = ~dy_reg[0];
    assign stat.empty     = (n_i == '0) || (n_j == '0);
    assign stat.last      = (i_reg == n_i - CNT_W'(1)) && (j_reg == n_j - CNT_W'(1));

    assign done          = done_reg;
    assign status        = status_reg;
    assign red_out       = pout_reg[23:16];
    assign green_out     = pout_reg[15:8];
    assign blue_out      = pout_reg[7:0];
    assign result_width  = rw_reg;
    assign result_height = rh_reg;

endmodule

/* design/imgrot_ctrl.sv */
// Controller: sequences pixel accesses and the phases of a rotation.
module imgrot_ctrl
    import imgrot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RWAIT,
        S_PSTART,
        S_RA,
        S_RB,
        S_WA,
        S_WB
    } state_t;

    state_t state_reg, state_next;
    op_t    phase_reg, phase_next;
    op_t    after;
    logic   finish_now;

    // phase that follows the current one
    always_comb
    begin
        unique case (phase_reg)
            OP_W2S:     after = OP_S2W;
            OP_P2S:
            begin
                priority if (stat.dx_gt_dy)
                    after = OP_PAINT_X;
                else if (stat.dx_lt_dy)
                    after = OP_PAINT_Y;
                else
                    after = OP_S2P;
            end
            OP_PAINT_X, OP_PAINT_Y: after = OP_S2P;
            OP_SWAP:    after = stat.dy_even ? OP_SWAP_MID : OP_NONE;
            default:    after = OP_NONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        finish_now = 1'b0;
        cmd        = '0;
        cmd.op     = phase_reg;
        cmd.sub    = SUB_NONE;
        cmd.status = STAT_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.kind)
                    KIND_WRITE:
                    begin
                        cmd.op     = OP_PIX;
                        cmd.sub    = SUB_WA;
                        finish_now = 1'b1;
                    end
                    KIND_READ:
                    begin
                        cmd.op     = OP_PIX;
                        cmd.sub    = SUB_RA;
                        state_next = S_RWAIT;
                    end
                    KIND_ROTATE:
                    begin
                        priority if (stat.rect_bad)
                        begin
                            cmd.status = STAT_BAD_RECT;
                            finish_now = 1'b1;
                        end
                        else if (stat.angle_bad)
                        begin
                            cmd.status = STAT_BAD_ANGLE;
                            finish_now = 1'b1;
                        end
                        else
                        begin
                            cmd.derive = 1'b1;
                            priority if (stat.angle_180)
                                phase_next = OP_SWAP;
                            else if (stat.whole)
                                phase_next = OP_W2S;
                            else
                                phase_next = OP_P2S;
                            state_next = S_PSTART;
                        end
                    end
                    default: finish_now = 1'b1;
                endcase
            end
            S_RWAIT:
            begin
                cmd.op       = OP_PIX;
                cmd.take_pix = 1'b1;
                finish_now   = 1'b1;
            end
            S_PSTART:
            begin
                cmd.clr_cnt = 1'b1;
                if (stat.empty)
                begin
                    phase_next = after;
                    cmd.swap_dims = (phase_reg == OP_W2S);
                    if (after == OP_NONE)
                        finish_now = 1'b1;
                end
                else if (phase_reg == OP_PAINT_X || phase_reg == OP_PAINT_Y)
                    state_next = S_WA;
                else
                    state_next = S_RA;
            end
            S_RA:
            begin
                cmd.sub    = SUB_RA;
                state_next = (phase_reg == OP_SWAP || phase_reg == OP_SWAP_MID) ? S_RB : S_WA;
            end
            S_RB:
            begin
                cmd.sub    = SUB_RB;
                state_next = S_WA;
            end
            S_WA, S_WB:
            begin
                cmd.sub = (state_reg == S_WA) ? SUB_WA : SUB_WB;
                if (state_reg == S_WA && (phase_reg == OP_PAINT_X || phase_reg == OP_PAINT_Y
                    || phase_reg == OP_SWAP || phase_reg == OP_SWAP_MID))
                    state_next = S_WB;
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.last)
                    begin
                        phase_next    = after;
                        cmd.swap_dims = (phase_reg == OP_W2S);
                        if (after == OP_NONE)
                            finish_now = 1'b1;
                        else
                            state_next = S_PSTART;
                    end
                    else if (phase_reg == OP_PAINT_X || phase_reg == OP_PAINT_Y)
                        state_next = S_WA;
                    else
                        state_next = S_RA;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (finish_now)
        begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* design/image_region_rotate.sv */
// Top level of the image region rotator: frame store with pixel access and rectangle rotation.
//
//  port group        direction  transfer
//  start/busy+items  in         transaction when start & !busy
//  done+results      out        one cycle strobe, no back-pressure
//  APB psel..pready  in/out     write at psel & penable & pwrite
//
// Pixel write finishes in S_DISPATCH; a pixel read goes on to S_RWAIT to take the data.
// Rotation: a whole-picture turn copies through the scratch memory and back, 180 swaps
// pixel pairs in place, and other angles copy the region out, paint strips white and
// copy the region back; the frame store has one port. busy stays high until done.
// Reset clears the control and dimension registers; the memories keep no reset.
module image_region_rotate
    import imgrot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [POS_W-1:0]   row,
    input  logic [POS_W-1:0]   column,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    output logic               done,
    output logic [1:0]         status,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic [DIM_W-1:0]   result_width,
    output logic [DIM_W-1:0]   result_height,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cmd_t             cmd;
    stat_t            stat;
    logic [DIM_W-1:0] cur_w, cur_h;
    logic [POS_W-1:0] x1, ty, x2, by;
    logic [ANG_W-1:0] ang;

    imgrot_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .swap_dims (cmd.swap_dims),
        .cur_w     (cur_w),
        .cur_h     (cur_h),
        .x1        (x1),
        .ty        (ty),
        .x2        (x2),
        .by        (by),
        .ang       (ang)
    );

    imgrot_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    imgrot_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (kind),
        .row           (row),
        .column        (column),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .cur_w         (cur_w),
        .cur_h         (cur_h),
        .x1            (x1),
        .ty            (ty),
        .x2            (x2),
        .by            (by),
        .ang           (ang),
        .done          (done),
        .status        (status),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .result_width  (result_width),
        .result_height (result_height)
    );

endmodule

/* tb/tb_image_region_rotate.sv */
// Testbench for image_region_rotate: directed and random pixel and rotation traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_image_region_rotate;
    import imgrot_pkg::*;

    class rotate_scoreboard;
        typedef struct {
            logic [1:0]       st;
            logic [PIX_W-1:0] pix;
            logic [DIM_W-1:0] w;
            logic [DIM_W-1:0] h;
        } outcome_t;

        logic [PIX_W-1:0] picture[0:DEPTH-1];
        logic [PIX_W-1:0] scratch[0:DEPTH-1];
        int cur_w, cur_h, lx, ty, rx, by, ang;
        outcome_t awaited[$];
        int errors;

        function new();
            cur_w = 64; cur_h = 64; lx = 0; ty = 0; rx = 63; by = 63; ang = 90;
            errors = 0;
        endfunction

        function logic [PIX_W-1:0] pget(int r, int c);
            if (r < 0 || c < 0 || r >= cur_h || c >= cur_w)
                return '0;
            return picture[r * SIDE + c];
        endfunction

        function void pset(int r, int c, logic [PIX_W-1:0] v);
            if (r < 0 || c < 0 || r >= cur_h || c >= cur_w)
                return;
            picture[r * SIDE + c] = v;
        endfunction

        function void sset(int i, int j, logic [PIX_W-1:0] v);
            if (i < 0 || j < 0 || i >= SIDE || j >= SIDE)
                return;
            scratch[i * SIDE + j] = v;
        endfunction

        function logic [PIX_W-1:0] sget(int i, int j);
            if (i < 0 || j < 0 || i >= SIDE || j >= SIDE)
                return '0;
            return scratch[i * SIDE + j];
        endfunction

        function void swap_pair(int ra, int ca, int rb, int cb);
            logic [PIX_W-1:0] t;
            t = pget(ra, ca);
            pset(ra, ca, pget(rb, cb));
            pset(rb, cb, t);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            int d;
            d = int'(v[6:0]);
            case (idx)
                REG_WIDTH:  cur_w = (d < 1) ? 1 : (d > MAX_WIDTH ? MAX_WIDTH : d);
                REG_HEIGHT: cur_h = (d < 1) ? 1 : (d > MAX_HEIGHT ? MAX_HEIGHT : d);
                REG_LEFT:   lx = int'(v[5:0]);
                REG_TOP:    ty = int'(v[5:0]);
                REG_RIGHT:  rx = int'(v[5:0]);
                REG_BOTTOM: by = int'(v[5:0]);
                REG_ANGLE:  ang = int'(v[8:0]);
                default: ;
            endcase
        endfunction

        function void turn_whole();
            int w, h;
            w = cur_w; h = cur_h;
            for (int i = 0; i < w; i++)
                for (int j = 0; j < h; j++)
                    sset(i, j, ang == 90 ? pget(j, w - 1 - i) : pget(h - 1 - j, i));
            cur_w = h; cur_h = w;
            for (int i = 0; i < w; i++)
                for (int j = 0; j < h; j++)
                    pset(i, j, sget(i, j));
        endfunction

        function void turn_part();
            int h, dx, dy, xc, yc, cur, sx, mtop, mbot;
            h = cur_h; dx = rx - lx; dy = by - ty;
            xc = (lx + rx) / 2; yc = (ty + by) / 2;
            cur = yc - ((dx % 2 == 0) ? dx / 2 : (dx + 1) / 2);
            sx = xc - ((dy % 2 == 0) ? dy / 2 : (dy + 1) / 2);
            mtop = h - 1 - ty; mbot = h - 1 - by;
            cur = h - 1 - cur;
            for (int i = 0; i <= dx; i++)
                for (int j = 0; j <= dy; j++)
                    sset(i, j, ang == 90 ? pget(mbot + j, lx + i) : pget(mtop - j, rx - i));
            if (dx > dy) begin
                for (int i = 0; i < (dx - dy) / 2; i++)
                    for (int j = 0; j <= dy; j++)
                    begin
                        pset(mtop - j, xc + (dy / 2 + i), WHITE);
                        pset(mtop - j, xc - (dy / 2 + i), WHITE);
                    end
            end
            else if (dx < dy) begin
                for (int i = 0; i <= (dy - dx) / 2; i++)
                    for (int j = 0; j <= dx; j++)
                    begin
                        pset(h - yc - 1 + (dx / 2 + i), lx + j, WHITE);
                        pset(h - yc - 1 - (dx / 2 + i), lx + j, WHITE);
                    end
            end
            for (int i = 0; i <= dx; i++)
                for (int j = 0; j <= dy; j++)
                    pset(cur - i, sx + j, sget(i, j));
        endfunction

        function void mirror_part();
            int mtop, mbot, dx, dy, mid;
            mtop = cur_h - 1 - ty; mbot = cur_h - 1 - by;
            dx = rx - lx; dy = mtop - mbot;
            for (int i = 0; i < (dy + 1) / 2; i++)
                for (int j = 0; j <= dx; j++)
                    swap_pair(mtop - i, lx + j, mbot + i, rx - j);
            if (dy % 2 == 0) begin
                mid = mtop - dy / 2;
                for (int i = 0; i < (dx + 1) / 2; i++)
                    swap_pair(mid, lx + i, mid, rx - i);
            end
        endfunction

        function logic [1:0] rotate_region();
            if (lx >= cur_w || rx >= cur_w || ty >= cur_h || by >= cur_h || rx < lx || by < ty)
                return STAT_BAD_RECT;
            if (ang != 90 && ang != 180 && ang != 270)
                return STAT_BAD_ANGLE;
            if (ang != 180 && lx == 0 && rx == cur_w - 1 && ty == 0 && by == cur_h - 1)
                turn_whole();
            else if (ang != 180)
                turn_part();
            else
                mirror_part();
            return STAT_OK;
        endfunction

        function void note_item(logic [1:0] k, int r, int c, logic [PIX_W-1:0] v);
            outcome_t o;
            o.st = STAT_OK;
            o.pix = '0;
            if (k == KIND_WRITE)
                pset(r, c, v);
            else if (k == KIND_READ)
                o.pix = pget(r, c);
            else if (k == KIND_ROTATE)
                o.st = rotate_region();
            o.w = DIM_W'(cur_w);
            o.h = DIM_W'(cur_h);
            awaited.push_back(o);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic [PIX_W-1:0] pix,
                          logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
            outcome_t o;
            if (awaited.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            o = awaited.pop_front();
            if (st !== o.st)
                report($sformatf("status %0d, expected %0d", st, o.st));
            if (pix !== o.pix)
                report($sformatf("pixel %06h, expected %06h", pix, o.pix));
            if (w !== o.w)
                report($sformatf("width %0d, expected %0d", w, o.w));
            if (h !== o.h)
                report($sformatf("height %0d, expected %0d", h, o.h));
        endtask
    endclass

    logic clk, rst_n, start, busy, done;
    logic [1:0] kind, status;
    logic [POS_W-1:0] row, column;
    logic [7:0] red_in, green_in, blue_in, red_out, green_out, blue_out;
    logic [DIM_W-1:0] result_width, result_height;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;

    rotate_scoreboard sb = new();
    int gap_pct;

    image_region_rotate dut (.*);

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("tb_image_region_rotate: FAIL");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(status, {red_out, green_out, blue_out}, result_width, result_height);

    task reg_write(logic [2:0] idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, v);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task send(logic [1:0] k, int r, int c, logic [PIX_W-1:0] v);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        kind <= k; row <= POS_W'(r); column <= POS_W'(c);
        {red_in, green_in, blue_in} <= v;
        do @(posedge clk); while (busy);
        sb.note_item(k, r, c, v);
    endtask

    task settle();
        start <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task set_region(int l, int t, int r, int b, int a);
        reg_write(REG_LEFT, l);
        reg_write(REG_TOP, t);
        reg_write(REG_RIGHT, r);
        reg_write(REG_BOTTOM, b);
        reg_write(REG_ANGLE, a);
    endtask

    task run_segment(int n);
        int w, h, l, r, t, b, a, sel;
        sel = $urandom_range(9);
        w = (sel == 0) ? 16 : $urandom_range(1, 16);
        h = (sel == 0) ? 16 : (sel == 1 ? w : $urandom_range(1, 16));
        reg_write(REG_WIDTH, (sel == 2) ? 32'($urandom_range(0, 16)) : w);
        reg_write(REG_HEIGHT, h);
        w = sb.cur_w; h = sb.cur_h;
        l = $urandom_range(w - 1); r = $urandom_range(l, w - 1);
        t = $urandom_range(h - 1); b = $urandom_range(t, h - 1);
        if ($urandom_range(4) == 0) begin
            l = 0; t = 0; r = w - 1; b = h - 1;
        end
        case ($urandom_range(9))
            0: a = $urandom_range(0, 511);
            1: begin l = $urandom_range(63); r = $urandom_range(63); end
            2, 3, 4: a = 90;
            5, 6: a = 180;
            default: a = 270;
        endcase
        if (a == 0 && $urandom_range(1)) a = 90;
        set_region(l, t, r, b, a == 0 ? 90 : a);
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 45)
                send(KIND_WRITE, sel < 5 ? $urandom_range(63) : $urandom_range(h - 1),
                     sel < 5 ? $urandom_range(63) : $urandom_range(w - 1), PIX_W'($urandom));
            else if (sel < 80)
                send(KIND_READ, sel < 50 ? $urandom_range(63) : $urandom_range(h - 1),
                     sel < 50 ? $urandom_range(63) : $urandom_range(w - 1), PIX_W'($urandom));
            else if (sel < 93)
                send(KIND_ROTATE, $urandom_range(63), $urandom_range(63), PIX_W'($urandom));
            else
                send(2'd3, $urandom_range(63), $urandom_range(63), PIX_W'($urandom));
            w = sb.cur_w; h = sb.cur_h;
        end
        settle();
    endtask

    initial begin
        rst_n = 1'b0; start = 1'b0; kind = KIND_WRITE; row = '0; column = '0;
        red_in = '0; green_in = '0; blue_in = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        gap_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry of the corner in use gets a defined value before anything is moved
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                send(KIND_WRITE, r, c, PIX_W'($urandom));
        settle();

        // directed
        send(KIND_WRITE, 0, 0, 24'h000000);
        send(KIND_WRITE, 63, 63, 24'hFFFFFF);
        send(KIND_READ, 0, 0, '0);
        send(KIND_READ, 63, 63, '0);
        send(2'd3, 63, 0, 24'hFFFFFF);
        settle();
        reg_write(REG_WIDTH, 0);
        reg_write(REG_HEIGHT, 127);
        reg_write(REG_WIDTH, 8);
        reg_write(REG_HEIGHT, 5);
        send(KIND_WRITE, 2, 40, 24'h123456);
        send(KIND_READ, 4, 8, '0);
        settle();
        set_region(5, 0, 1, 2, 90);
        send(KIND_ROTATE, 0, 0, '0);
        settle();
        set_region(0, 0, 7, 4, 0);
        send(KIND_ROTATE, 0, 0, '0);
        settle();
        reg_write(REG_ANGLE, 511);
        send(KIND_ROTATE, 0, 0, '0);
        settle();
        set_region(1, 1, 6, 3, 180);
        send(KIND_ROTATE, 0, 0, '0);
        send(KIND_READ, 2, 3, '0);
        settle();
        reg_write(REG_ANGLE, 90);
        send(KIND_ROTATE, 0, 0, '0);
        settle();
        set_region(2, 0, 3, 4, 270);
        send(KIND_ROTATE, 0, 0, '0);
        settle();
        set_region(0, 0, 7, 4, 90);
        send(KIND_ROTATE, 0, 0, '0);
        send(KIND_READ, 7, 4, '0);
        settle();
        set_region(0, 0, 4, 7, 270);
        send(KIND_ROTATE, 0, 0, '0);
        settle();

        for (int p = 0; p < 9; p++) begin
            gap_pct = (p < 3) ? 8 : (p < 6 ? 88 : 0);
            run_segment(25);
        end

        settle();
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb_image_region_rotate: PASS");
        else
            $display("tb_image_region_rotate: FAIL");
        $finish;
    end
endmodule

/* files.f */
design/imgrot_pkg.sv
design/imgrot_regs.sv
design/imgrot_dp.sv
design/imgrot_ctrl.sv
design/image_region_rotate.sv
tb/tb_image_region_rotate.sv
